/* rtl/core/asmt_pkg.sv */
// Shared types and constants of the assembly tokenizer core.
// Used by the front end, the entry queue, the back end and the top level.
package asmt_pkg;

	localparam int MAX_WORD   = 255;
	localparam int POS_W      = 16;
	localparam int VALUE_W    = 64;
	localparam int LEN_W      = 8;
	localparam int INQ_DEPTH  = 2;
	localparam int OUTQ_DEPTH = 4;

	localparam logic [VALUE_W-1:0] REG_RSP = VALUE_W'(254);
	localparam logic [VALUE_W-1:0] REG_RBP = VALUE_W'(255);

	typedef enum logic [2:0] {
		K_END     = 3'd0,
		K_EOL     = 3'd1,
		K_COMMA   = 3'd2,
		K_REG     = 3'd3,
		K_LABEL   = 3'd4,
		K_NUM     = 3'd5,
		K_IDENT   = 3'd6,
		K_INVALID = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		NM_NONE = 3'd0,
		NM_R    = 3'd1,
		NM_RS   = 3'd2,
		NM_RB   = 3'd3,
		NM_RSP  = 3'd4,
		NM_RBP  = 3'd5
	} name_match_t;

	typedef enum logic [1:0] {
		HP_IDLE   = 2'd0,
		HP_ZERO   = 2'd1,
		HP_DIGITS = 2'd2,
		HP_DONE   = 2'd3
	} hex_phase_t;

	// Classified input transaction, as queued between front and back end
	typedef struct packed {
		logic             func;
		logic [POS_W-1:0] pos;
		logic             is_ws;
		logic             is_nl;
		logic             is_comma;
		logic             is_colon;
		logic             is_word;
		logic             is_digit;
		logic             is_zero;
		logic             is_r;
		logic             is_s;
		logic             is_b;
		logic             is_p;
		logic             is_x;
		logic             hex_ok;
		logic [3:0]       hex_val;
	} entry_t;

	typedef struct packed {
		logic   push;
		entry_t entry;
	} inq_wr_t;

	typedef struct packed {
		logic   valid;
		logic   full;
		entry_t head;
	} inq_rd_t;

	typedef struct packed {
		kind_t              kind;
		logic [VALUE_W-1:0] value;
		logic [POS_W-1:0]   start;
		logic [LEN_W-1:0]   len;
		logic               last;
	} tok_t;

endpackage

/* rtl/core/asmt_front.sv */
// Front end: accepts input transactions, classifies the byte and tags it with its offset.
// Tracks position and end of input; depends on asmt_pkg.
module asmt_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      func,
	input  logic [7:0]                source_byte,
	input  asmt_pkg::inq_rd_t         inq_rd,
	output asmt_pkg::inq_wr_t         inq_wr
);

	logic [asmt_pkg::POS_W-1:0] pos_q;
	logic                       finished_q;
	logic                       accept;
	asmt_pkg::entry_t           e;
	logic [7:0]                 c;

	// Drop everything once end of input has been seen
	assign in_ready = finished_q | ~inq_rd.full;
	assign accept   = in_valid & in_ready;

	always_comb begin
		c          = source_byte;
		e.func     = func;
		e.pos      = pos_q;
		e.is_ws    = c inside {8'h20, 8'h09, 8'h0C, 8'h0B};
		e.is_nl    = (c == 8'h0A);
		e.is_comma = (c == 8'h2C);
		e.is_colon = (c == 8'h3A);
		e.is_digit = c inside {[8'h30:8'h39]};
		e.is_word  = c inside {[8'h30:8'h39], [8'h61:8'h7A], [8'h41:8'h5A], 8'h5F};
		e.is_zero  = (c == 8'h30);
		e.is_r     = (c == 8'h72);
		e.is_s     = (c == 8'h73);
		e.is_b     = (c == 8'h62);
		e.is_p     = (c == 8'h70);
		e.is_x     = (c == 8'h78) || (c == 8'h58);
		e.hex_ok   = 1'b1;
		e.hex_val  = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			e.hex_val = 4'(c - 8'h30);
		end else if (c inside {[8'h61:8'h66]}) begin
			e.hex_val = 4'(c - 8'h57);
		end else if (c inside {[8'h41:8'h46]}) begin
			e.hex_val = 4'(c - 8'h37);
		end else begin
			e.hex_ok = 1'b0;
		end
		inq_wr.push  = accept & ~finished_q;
		inq_wr.entry = e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			finished_q <= 1'b0;
		end else if (accept && !finished_q) begin
			if (func) begin
				finished_q <= 1'b1;
			end else if (pos_q != '1) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

/* rtl/core/asmt_queue.sv */
// Two-entry queue of classified transactions between front and back end.
// Depends on asmt_pkg.
module asmt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  asmt_pkg::inq_wr_t inq_wr,
	input  logic              pop,
	output asmt_pkg::inq_rd_t inq_rd
);

	localparam int AW = $clog2(asmt_pkg::INQ_DEPTH);

	asmt_pkg::entry_t mem_q [asmt_pkg::INQ_DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      cnt_q;
	logic             do_pop;

	assign inq_rd.valid = (cnt_q != '0);
	assign inq_rd.full  = (cnt_q == (AW+1)'(asmt_pkg::INQ_DEPTH));
	assign inq_rd.head  = mem_q[rd_ptr_q];
	assign do_pop       = pop & inq_rd.valid;

	always_ff @(posedge clk) begin
		if (inq_wr.push) begin
			mem_q[wr_ptr_q] <= inq_wr.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (inq_wr.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(inq_wr.push) - (AW+1)'(do_pop);
		end
	end

endmodule

/* rtl/core/asmt_back.sv */
// Back end: word state machine of the lexer and the token output queue.
// Takes classified transactions from asmt_queue; depends on asmt_pkg.
module asmt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  asmt_pkg::inq_rd_t  inq_rd,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output asmt_pkg::tok_t     out_tok
);

	localparam int OAW = $clog2(asmt_pkg::OUTQ_DEPTH);
	localparam int VW  = asmt_pkg::VALUE_W;

	function automatic logic [VW-1:0] mac10(input logic [VW-1:0] acc, input logic [3:0] d);
		logic [VW+3:0] sum;
		sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + (VW+4)'(d);
		return (|sum[VW+3:VW]) ? '1 : sum[VW-1:0];
	endfunction

	function automatic logic [VW-1:0] mac16(input logic [VW-1:0] acc, input logic [3:0] d);
		return (|acc[VW-1:VW-4]) ? '1 : {acc[VW-5:0], d};
	endfunction

	logic                                 in_word_q, in_word_d;
	logic [asmt_pkg::POS_W-1:0]           word_start_q, word_start_d;
	logic [asmt_pkg::LEN_W-1:0]           word_count_q, word_count_d;
	logic                                 first_r_q, first_r_d;
	logic                                 first_digit_q, first_digit_d;
	logic                                 dig_only_q, dig_only_d;
	logic [VW-1:0]                        dec_acc_q, dec_acc_d;
	logic [VW-1:0]                        hex_acc_q, hex_acc_d;
	asmt_pkg::hex_phase_t                 hex_phase_q, hex_phase_d;
	asmt_pkg::name_match_t                name_q, name_d;
	logic                                 overlong_q, overlong_d;

	asmt_pkg::tok_t                       oq_q [asmt_pkg::OUTQ_DEPTH];
	logic [OAW-1:0]                       oq_wr_q;
	logic [OAW-1:0]                       oq_rd_q;
	logic [OAW:0]                         oq_cnt_q;

	asmt_pkg::entry_t                     e;
	asmt_pkg::tok_t                       r0, r1, wtok, alone;
	logic [1:0]                           n;
	logic                                 step;
	logic                                 out_pop;
	logic                                 colon_used;
	logic                                 handled;
	logic                                 has_alone;
	logic                                 wc;
	logic                                 wc_first;
	logic                                 hex_go;

	assign e       = inq_rd.head;
	assign step    = inq_rd.valid && (oq_cnt_q <= (OAW+1)'(asmt_pkg::OUTQ_DEPTH - 2));
	assign pop     = step;
	assign out_valid = (oq_cnt_q != '0);
	assign out_tok = oq_q[oq_rd_q];
	assign out_pop = out_valid & out_ready;

	// Token for the word that ends here
	always_comb begin
		wtok       = '{kind: asmt_pkg::K_IDENT, value: '0, start: word_start_q,
		               len: word_count_q, last: 1'b0};
		colon_used = 1'b0;
		if (overlong_q) begin
			wtok.kind = asmt_pkg::K_INVALID;
			wtok.len  = '0;
		end else if (first_r_q && word_count_q >= 8'd2 && dig_only_q) begin
			wtok.kind  = asmt_pkg::K_REG;
			wtok.value = dec_acc_q;
			wtok.len   = '0;
		end else if (name_q == asmt_pkg::NM_RSP) begin
			wtok.kind  = asmt_pkg::K_REG;
			wtok.value = asmt_pkg::REG_RSP;
			wtok.len   = '0;
		end else if (name_q == asmt_pkg::NM_RBP) begin
			wtok.kind  = asmt_pkg::K_REG;
			wtok.value = asmt_pkg::REG_RBP;
			wtok.len   = '0;
		end else if (e.is_colon && !e.func) begin
			wtok.kind  = asmt_pkg::K_LABEL;
			colon_used = 1'b1;
		end else if (first_digit_q) begin
			wtok.kind  = asmt_pkg::K_NUM;
			wtok.value = hex_acc_q;
			wtok.len   = '0;
		end
	end

	always_comb begin
		in_word_d     = in_word_q;
		word_start_d  = word_start_q;
		word_count_d  = word_count_q;
		first_r_d     = first_r_q;
		first_digit_d = first_digit_q;
		dig_only_d    = dig_only_q;
		dec_acc_d     = dec_acc_q;
		hex_acc_d     = hex_acc_q;
		hex_phase_d   = hex_phase_q;
		name_d        = name_q;
		overlong_d    = overlong_q;
		r0            = '{kind: asmt_pkg::K_END, value: '0, start: e.pos, len: '0, last: 1'b0};
		r1            = r0;
		alone         = r0;
		n             = 2'd0;
		handled       = 1'b0;
		has_alone     = 1'b0;
		wc            = 1'b0;
		wc_first      = 1'b0;
		hex_go        = 1'b0;

		if (e.func) begin
			if (in_word_q) begin
				r0 = wtok;
				n  = 2'd2;
			end else begin
				n = 2'd1;
			end
			in_word_d = 1'b0;
		end else begin
			if (in_word_q) begin
				if (e.is_word) begin
					wc      = 1'b1;
					handled = 1'b1;
				end else begin
					r0        = wtok;
					n         = 2'd1;
					in_word_d = 1'b0;
					handled   = colon_used;
				end
			end
			if (!handled) begin
				has_alone = 1'b1;
				if (e.is_ws) begin
					has_alone = 1'b0;
				end else if (e.is_nl) begin
					alone.kind = asmt_pkg::K_EOL;
				end else if (e.is_comma) begin
					alone.kind = asmt_pkg::K_COMMA;
				end else if (e.is_colon) begin
					alone.kind = asmt_pkg::K_LABEL;
				end else if (e.is_word) begin
					has_alone    = 1'b0;
					in_word_d    = 1'b1;
					word_start_d = e.pos;
					overlong_d   = 1'b0;
					wc           = 1'b1;
					wc_first     = 1'b1;
				end else begin
					alone.kind = asmt_pkg::K_INVALID;
				end
				if (has_alone) begin
					if (n == 2'd0) begin
						r0 = alone;
					end else begin
						r1 = alone;
					end
					n = n + 2'd1;
				end
			end
		end

		if (wc) begin
			if (wc_first) begin
				word_count_d  = 8'd1;
				first_r_d     = e.is_r;
				first_digit_d = e.is_digit;
				dig_only_d    = e.is_r;
				dec_acc_d     = '0;
				name_d        = e.is_r ? asmt_pkg::NM_R : asmt_pkg::NM_NONE;
				if (e.is_zero) begin
					hex_phase_d = asmt_pkg::HP_ZERO;
					hex_acc_d   = '0;
				end else if (e.is_digit) begin
					hex_phase_d = asmt_pkg::HP_DIGITS;
					hex_acc_d   = VW'(e.hex_val);
				end else begin
					hex_phase_d = asmt_pkg::HP_DONE;
					hex_acc_d   = '0;
				end
			end else if (word_count_q >= asmt_pkg::LEN_W'(asmt_pkg::MAX_WORD)) begin
				overlong_d = 1'b1;
			end else begin
				word_count_d = word_count_q + 1'b1;
				if (!e.is_digit) begin
					dig_only_d = 1'b0;
				end else begin
					dec_acc_d = mac10(dec_acc_q, e.hex_val);
				end
				case (word_count_q)
					8'd1: begin
						if (name_q == asmt_pkg::NM_R && e.is_s) begin
							name_d = asmt_pkg::NM_RS;
						end else if (name_q == asmt_pkg::NM_R && e.is_b) begin
							name_d = asmt_pkg::NM_RB;
						end else begin
							name_d = asmt_pkg::NM_NONE;
						end
					end
					8'd2: begin
						if (name_q == asmt_pkg::NM_RS && e.is_p) begin
							name_d = asmt_pkg::NM_RSP;
						end else if (name_q == asmt_pkg::NM_RB && e.is_p) begin
							name_d = asmt_pkg::NM_RBP;
						end else begin
							name_d = asmt_pkg::NM_NONE;
						end
					end
					default: name_d = asmt_pkg::NM_NONE;
				endcase
				// Skip the x of a 0x prefix; otherwise fold the digit
				if (hex_phase_q == asmt_pkg::HP_ZERO) begin
					hex_phase_d = asmt_pkg::HP_DIGITS;
					hex_go      = ~e.is_x;
				end else begin
					hex_go = (hex_phase_q == asmt_pkg::HP_DIGITS);
				end
				if (hex_go) begin
					if (e.hex_ok) begin
						hex_acc_d = mac16(hex_acc_q, e.hex_val);
					end else begin
						hex_phase_d = asmt_pkg::HP_DONE;
					end
				end
			end
		end

		if (n == 2'd1) begin
			r0.last = 1'b1;
		end
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q     <= 1'b0;
			word_start_q  <= '0;
			word_count_q  <= '0;
			first_r_q     <= 1'b0;
			first_digit_q <= 1'b0;
			dig_only_q    <= 1'b0;
			dec_acc_q     <= '0;
			hex_acc_q     <= '0;
			hex_phase_q   <= asmt_pkg::HP_IDLE;
			name_q        <= asmt_pkg::NM_NONE;
			overlong_q    <= 1'b0;
		end else if (step) begin
			in_word_q     <= in_word_d;
			word_start_q  <= word_start_d;
			word_count_q  <= word_count_d;
			first_r_q     <= first_r_d;
			first_digit_q <= first_digit_d;
			dig_only_q    <= dig_only_d;
			dec_acc_q     <= dec_acc_d;
			hex_acc_q     <= hex_acc_d;
			hex_phase_q   <= hex_phase_d;
			name_q        <= name_d;
			overlong_q    <= overlong_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && n != 2'd0) begin
			oq_q[oq_wr_q] <= r0;
		end
		if (step && n == 2'd2) begin
			oq_q[oq_wr_q + 1'b1] <= r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (step) begin
				oq_wr_q <= oq_wr_q + OAW'(n);
			end
			if (out_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			oq_cnt_q <= oq_cnt_q + (step ? (OAW+1)'(n) : '0) - (OAW+1)'(out_pop);
		end
	end

`ifndef ASSERT_OFF
	a_oq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oq_cnt_q <= (OAW+1)'(asmt_pkg::OUTQ_DEPTH))
		else $error("token queue overfilled");
	a_step_room: assert property (@(posedge clk) disable iff (!arst_n)
		step |-> oq_cnt_q <= (OAW+1)'(asmt_pkg::OUTQ_DEPTH - 2))
		else $error("transaction taken without room for two tokens");
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_tok.kind == asmt_pkg::K_END) |-> out_tok.last)
		else $error("end token not marked last");
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && e.func) |=> !in_word_q)
		else $error("word still open after end of input");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		word_count_q <= asmt_pkg::LEN_W'(asmt_pkg::MAX_WORD))
		else $error("word length beyond limit");
`endif

endmodule

/* rtl/core/assembly_tokenizer_core.sv */
// Assembly tokenizer core: takes one source byte or end-of-input marker per transaction
// and hands out tokens one per transaction. Throughput is one input byte per clock while
// the token queue has room for two tokens; the back end's word state update and its
// four-token output queue set that figure. A byte passes through the entry queue, then
// the token queue, on its way to its token. After end of input every
// transaction is accepted and dropped. Depends on asmt_pkg, asmt_front, asmt_queue, asmt_back.
module assembly_tokenizer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [7:0]  source_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [63:0] value,
	output logic [15:0] start_offset,
	output logic [7:0]  word_length,
	output logic        last
);

	asmt_pkg::inq_wr_t inq_wr;
	asmt_pkg::inq_rd_t inq_rd;
	asmt_pkg::tok_t    tok;
	logic              pop;

	asmt_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.source_byte (source_byte),
		.inq_rd      (inq_rd),
		.inq_wr      (inq_wr)
	);

	asmt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.inq_wr (inq_wr),
		.pop    (pop),
		.inq_rd (inq_rd)
	);

	asmt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.inq_rd    (inq_rd),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_tok   (tok)
	);

	assign kind         = 3'(tok.kind);
	assign value        = tok.value;
	assign start_offset = tok.start;
	assign word_length  = tok.len;
	assign last         = tok.last;

endmodule
